// ----- rtl/mstt_pkg.sv -----
`timescale 1ns / 1ps
package mstt_pkg;

   localparam int DATA_W      = 32;
   localparam int TID_W       = 16;
   localparam int SLOTS_DEF   = 16;
   localparam int ID_BITS_DEF = 16;
   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 56;

   typedef enum logic [2:0] {
      OP_SET_TIMEOUT  = 3'd0,
      OP_SET_INTERVAL = 3'd1,
      OP_CANCEL       = 3'd2,
      OP_PAUSE        = 3'd3,
      OP_RESUME       = 3'd4,
      OP_QUERY        = 3'd5,
      OP_CANCEL_ALL   = 3'd6,
      OP_TICK         = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_INVALID   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      RK_OK,
      RK_INVALID,
      RK_NOT_FOUND,
      RK_FULL,
      RK_CREATED,
      RK_FIRE,
      RK_QUERY
   } rsp_kind_type;

   typedef struct packed {
      logic         capture;
      logic         clear_all;
      logic         idx_clr;
      logic         idx_inc;
      logic         wr_create;
      logic         wr_rem_sub;
      logic         wr_rem_reload;
      logic         free_slot;
      logic         set_pause;
      logic         clr_pause;
      logic         mod_start;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   tid_zero;
      logic   dur_zero;
      logic   slot_valid;
      logic   slot_paused;
      logic   id_match;
      logic   expire;
      logic   has_interval;
      logic   idx_last;
      logic   mod_done;
      logic   out_free;
   } stat_type;

endpackage

// ----- rtl/mstt_mod_unit.sv -----
`timescale 1ns / 1ps
module mstt_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mstt_pkg::DATA_W-1:0] dividend,
   input  logic [mstt_pkg::DATA_W-1:0] divisor,
   output logic                        done,
   output logic [mstt_pkg::DATA_W-1:0] remainder
);
   import mstt_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic [DATA_W:0]   rem_ff, rem_in, trial;
   logic [DATA_W-1:0] quo_ff, div_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff, done_ff;

   // one restoring step a cycle, remainder only
   always_comb begin
      trial = {rem_ff[DATA_W-1:0], quo_ff[DATA_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = trial - {1'b0, div_ff};
      end else begin
         rem_in = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DATA_W-2:0], 1'b0};
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[DATA_W-1:0];

endmodule

// ----- rtl/mstt_datapath.sv -----
`timescale 1ns / 1ps
module mstt_datapath #(
   parameter int SLOTS   = mstt_pkg::SLOTS_DEF,
   parameter int ID_BITS = mstt_pkg::ID_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mstt_pkg::cmd_type               cmd,
   output mstt_pkg::stat_type              stat,
   input  logic [2:0]                      req_tuser,
   input  logic [mstt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mstt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import mstt_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMP_W = (ID_BITS > TID_W) ? ID_BITS : TID_W;

   op_type             op_ff;
   logic [TID_W-1:0]   tid_ff;
   logic [DATA_W-1:0]  dur_ff, delta_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [SLOTS-1:0]   valid_ff, paused_ff;
   logic [ID_BITS-1:0] next_id_ff, next_id_in, new_id_ff;

   logic [ID_BITS-1:0] slot_id_ff  [SLOTS];
   logic [DATA_W-1:0]  slot_rem_ff [SLOTS];
   logic [DATA_W-1:0]  slot_int_ff [SLOTS];
   logic [ID_BITS-1:0] rd_id_ff;
   logic [DATA_W-1:0]  rd_rem_ff, rd_int_ff;

   logic [DATA_W-1:0]  mod_rem;
   logic               mod_done;

   logic               rsp_valid_ff, out_free;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   mstt_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (delta_ff - rd_rem_ff),
      .divisor   (rd_int_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // next id wraps and skips zero
   always_comb begin
      next_id_in = next_id_ff + 1'b1;
      if (next_id_in == '0) begin
         next_id_in = ID_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_tuser);
         tid_ff   <= req_tdata[TID_W-1:0];
         dur_ff   <= req_tdata[TID_W +: DATA_W];
         delta_ff <= req_tdata[TID_W+DATA_W +: DATA_W];
      end
      if (cmd.wr_create) begin
         new_id_ff <= next_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         valid_ff   <= '0;
         paused_ff  <= '0;
         next_id_ff <= ID_BITS'(1);
      end else begin
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.clear_all) begin
            valid_ff  <= '0;
            paused_ff <= '0;
         end
         if (cmd.wr_create) begin
            valid_ff[idx_ff]  <= 1'b1;
            paused_ff[idx_ff] <= 1'b0;
            next_id_ff        <= next_id_in;
         end
         if (cmd.free_slot) begin
            valid_ff[idx_ff]  <= 1'b0;
            paused_ff[idx_ff] <= 1'b0;
         end
         if (cmd.set_pause) begin
            paused_ff[idx_ff] <= 1'b1;
         end
         if (cmd.clr_pause) begin
            paused_ff[idx_ff] <= 1'b0;
         end
      end
   end

   // slot memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_create) begin
         slot_id_ff[idx_ff]  <= next_id_ff;
         slot_rem_ff[idx_ff] <= dur_ff;
         slot_int_ff[idx_ff] <= (op_ff == OP_SET_INTERVAL) ? dur_ff : '0;
      end else if (cmd.wr_rem_sub) begin
         slot_rem_ff[idx_ff] <= rd_rem_ff - delta_ff;
      end else if (cmd.wr_rem_reload) begin
         slot_rem_ff[idx_ff] <= rd_int_ff - mod_rem;
      end
      rd_id_ff  <= slot_id_ff[idx_ff];
      rd_rem_ff <= slot_rem_ff[idx_ff];
      rd_int_ff <= slot_int_ff[idx_ff];
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_data_in = '0;
      unique case (cmd.rsp_kind)
         RK_OK:        rsp_data_in[1:0] = ST_OK;
         RK_INVALID:   rsp_data_in[1:0] = ST_INVALID;
         RK_NOT_FOUND: rsp_data_in[1:0] = ST_NOT_FOUND;
         RK_FULL:      rsp_data_in[1:0] = ST_FULL;
         RK_CREATED: begin
            rsp_data_in[1:0]  = ST_OK;
            rsp_data_in[17:2] = TID_W'(new_id_ff);
         end
         RK_FIRE: begin
            rsp_data_in[1:0]  = ST_OK;
            rsp_data_in[17:2] = TID_W'(rd_id_ff);
            rsp_data_in[18]   = 1'b1;
         end
         RK_QUERY: begin
            rsp_data_in[1:0]   = ST_OK;
            rsp_data_in[19]    = 1'b1;
            rsp_data_in[20]    = !paused_ff[idx_ff];
            rsp_data_in[52:21] = rd_rem_ff;
         end
         default: rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_tlast   <= (cmd.rsp_kind != RK_FIRE);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      stat.op           = op_ff;
      stat.tid_zero     = (tid_ff == '0);
      stat.dur_zero     = (dur_ff == '0);
      stat.slot_valid   = valid_ff[idx_ff];
      stat.slot_paused  = paused_ff[idx_ff];
      stat.id_match     = (CMP_W'(rd_id_ff) == CMP_W'(tid_ff));
      stat.expire       = (rd_rem_ff <= delta_ff);
      stat.has_interval = (rd_int_ff != '0);
      stat.idx_last     = (idx_ff == IDX_W'(SLOTS - 1));
      stat.mod_done     = mod_done;
      stat.out_free     = out_free;
   end

endmodule

// ----- rtl/mstt_ctrl.sv -----
`timescale 1ns / 1ps
module mstt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   output logic               ready,
   input  mstt_pkg::stat_type stat,
   output mstt_pkg::cmd_type  cmd
);
   import mstt_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DECODE = 8'b0000_0010,
      S_READ   = 8'b0000_0100,
      S_EVAL   = 8'b0000_1000,
      S_FIRE   = 8'b0001_0000,
      S_MODW   = 8'b0010_0000,
      S_NEXT   = 8'b0100_0000,
      S_EMIT   = 8'b1000_0000
   } state_type;

   state_type    state_ff, state_in;
   rsp_kind_type kind_ff, kind_in;
   logic         is_create;

   assign is_create = (stat.op == OP_SET_TIMEOUT) || (stat.op == OP_SET_INTERVAL);
   assign ready     = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.rsp_kind = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (stat.op == OP_CANCEL_ALL) begin
               cmd.clear_all = 1'b1;
               kind_in       = RK_OK;
               state_in      = S_EMIT;
            end else if (stat.op == OP_SET_INTERVAL && stat.dur_zero) begin
               kind_in  = RK_INVALID;
               state_in = S_EMIT;
            end else if (!is_create && stat.op != OP_TICK && stat.tid_zero) begin
               kind_in  = RK_INVALID;
               state_in = S_EMIT;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            state_in = S_NEXT;
            if (is_create) begin
               if (!stat.slot_valid) begin
                  cmd.wr_create = 1'b1;
                  kind_in       = RK_CREATED;
                  state_in      = S_EMIT;
               end
            end else if (stat.op == OP_TICK) begin
               if (stat.slot_valid && !stat.slot_paused) begin
                  if (stat.expire) begin
                     state_in = S_FIRE;
                  end else begin
                     cmd.wr_rem_sub = 1'b1;
                  end
               end
            end else if (stat.slot_valid && stat.id_match) begin
               kind_in  = RK_OK;
               state_in = S_EMIT;
               unique case (stat.op)
                  OP_CANCEL: cmd.free_slot = 1'b1;
                  OP_PAUSE:  cmd.set_pause = 1'b1;
                  OP_RESUME: cmd.clr_pause = 1'b1;
                  default:   kind_in       = RK_QUERY;
               endcase
            end
         end
         S_FIRE: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RK_FIRE;
               if (stat.has_interval) begin
                  cmd.mod_start = 1'b1;
                  state_in      = S_MODW;
               end else begin
                  cmd.free_slot = 1'b1;
                  state_in      = S_NEXT;
               end
            end
         end
         S_MODW: begin
            if (stat.mod_done) begin
               cmd.wr_rem_reload = 1'b1;
               state_in          = S_NEXT;
            end
         end
         S_NEXT: begin
            if (stat.idx_last) begin
               priority if (is_create) begin
                  kind_in = RK_FULL;
               end else if (stat.op == OP_TICK) begin
                  kind_in = RK_OK;
               end else begin
                  kind_in = RK_NOT_FOUND;
               end
               state_in = S_EMIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_READ;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= RK_OK;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ----- rtl/multi_slot_timer_table.sv -----
`timescale 1ns / 1ps
// Sequencing: cancel_all and rejected requests go from decode straight to the response;
// slot walks pass the read, eval and next states for each slot visited, a fired one-shot
// slot adds the fire state and a fired periodic slot adds fire plus a wait on its bit-serial
// remainder, and fire and emit wait while the response register is full; a tick visits every
// slot, a create or a lookup stops at the first free or matching slot.
// Throughput: one request at a time; the next is taken in the cycle after its final result
// is queued.
// Reset: synchronous active high; clears slot valid and paused bits and sets next id to 1.
module multi_slot_timer_table #(
   parameter int SLOTS   = mstt_pkg::SLOTS_DEF,
   parameter int ID_BITS = mstt_pkg::ID_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata: timer_id[15:0], duration[47:16], tick_delta[79:48]
   input  logic [mstt_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: op[2:0]
   input  logic [2:0]                      req_tuser,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata: status[1:0], result_id[17:2], fired[18], exists[19], active[20],
   //            remaining[52:21], zero pad[55:53]
   output logic [mstt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import mstt_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     accept;

   // a request transaction completes only while the sequencer is idle
   assign accept = req_tvalid && req_tready;

   // sequencer: walks slots, drives the datapath by commands
   mstt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .ready  (req_tready),
      .stat   (stat),
      .cmd    (cmd)
   );

   // slot store, id counter, remainder unit and the response register
   mstt_datapath #(
      .SLOTS   (SLOTS),
      .ID_BITS (ID_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the multi-slot timer table.
// A behavioural copy of the table predicts every response; a receiver process pops each
// response transaction and compares it field by field with the oldest prediction.
module tb_top;
   import mstt_pkg::*;

   localparam int NSLOT      = 16;
   localparam int IDLE_LIMIT = 6000;

   typedef struct {
      status_type  status;
      logic [15:0] result_id;
      logic        fired;
      logic        exists;
      logic        active;
      logic [31:0] remaining;
      logic        last;
   } timer_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   multi_slot_timer_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // shadow copy of the timer table
   logic        tbl_valid  [NSLOT];
   logic        tbl_paused [NSLOT];
   logic [15:0] tbl_id     [NSLOT];
   longint      tbl_rem    [NSLOT];
   logic [31:0] tbl_ivl    [NSLOT];
   logic [15:0] tbl_next_id;

   timer_rsp_type expected_rsp[$];
   int         errors      = 0;
   int         gap_max     = 13;
   int         stall_max   = 13;
   int         hold_cycles = 0;
   int         idle_count  = 0;

   task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
      $display("mismatch: %s expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
      errors++;
   endtask

   function automatic void push_rsp(input status_type st, input logic [15:0] rid,
                                    input logic fired, input logic ex, input logic act,
                                    input logic [31:0] rem, input logic last);
      timer_rsp_type r;
      r.status = st; r.result_id = rid; r.fired = fired; r.exists = ex;
      r.active = act; r.remaining = rem; r.last = last;
      expected_rsp = {expected_rsp, r};
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < NSLOT; i++) begin
         tbl_valid[i] = 1'b0; tbl_paused[i] = 1'b0;
      end
   endfunction

   // predict the responses of one accepted request and advance the shadow table
   function automatic void predict_timer_op(input op_type op, input logic [15:0] tid,
                                            input logic [31:0] dur, input logic [31:0] delta);
      int     s;
      longint r;
      longint unsigned over;
      s = -1;
      case (op)
         OP_SET_TIMEOUT, OP_SET_INTERVAL: begin
            if (op == OP_SET_INTERVAL && dur == 0) begin
               push_rsp(ST_INVALID, 0, 0, 0, 0, 0, 1);
               return;
            end
            for (int i = NSLOT - 1; i >= 0; i--) if (!tbl_valid[i]) s = i;
            if (s < 0) begin
               push_rsp(ST_FULL, 0, 0, 0, 0, 0, 1);
               return;
            end
            tbl_valid[s] = 1'b1; tbl_paused[s] = 1'b0;
            tbl_id[s] = tbl_next_id; tbl_rem[s] = longint'(dur);
            tbl_ivl[s] = (op == OP_SET_INTERVAL) ? dur : 32'd0;
            push_rsp(ST_OK, tbl_next_id, 0, 0, 0, 0, 1);
            tbl_next_id = tbl_next_id + 16'd1;
            if (tbl_next_id == 0) tbl_next_id = 16'd1;
         end
         OP_CANCEL_ALL: begin
            clear_table();
            push_rsp(ST_OK, 0, 0, 0, 0, 0, 1);
         end
         OP_TICK: begin
            for (int i = 0; i < NSLOT; i++) begin
               if (tbl_valid[i] && !tbl_paused[i]) begin
                  r = tbl_rem[i] - longint'(delta);
                  if (r <= 0) begin
                     push_rsp(ST_OK, tbl_id[i], 1, 0, 0, 0, 0);
                     if (tbl_ivl[i] != 0) begin
                        over = longint'(-r) % longint'(tbl_ivl[i]);
                        r = longint'(tbl_ivl[i]) - longint'(over);
                     end else begin
                        tbl_valid[i] = 1'b0; tbl_paused[i] = 1'b0; r = 0;
                     end
                  end
                  tbl_rem[i] = r;
               end
            end
            push_rsp(ST_OK, 0, 0, 0, 0, 0, 1);
         end
         default: begin
            if (tid == 0) begin
               push_rsp(ST_INVALID, 0, 0, 0, 0, 0, 1);
               return;
            end
            for (int i = NSLOT - 1; i >= 0; i--) if (tbl_valid[i] && tbl_id[i] == tid) s = i;
            if (s < 0) begin
               push_rsp(ST_NOT_FOUND, 0, 0, 0, 0, 0, 1);
               return;
            end
            case (op)
               OP_CANCEL: begin tbl_valid[s] = 1'b0; tbl_paused[s] = 1'b0; end
               OP_PAUSE:  tbl_paused[s] = 1'b1;
               OP_RESUME: tbl_paused[s] = 1'b0;
               default: begin
                  push_rsp(ST_OK, 0, 0, 1, !tbl_paused[s],
                           tbl_rem[s] > 0 ? tbl_rem[s][31:0] : 32'd0, 1);
                  return;
               end
            endcase
            push_rsp(ST_OK, 0, 0, 0, 0, 0, 1);
         end
      endcase
   endfunction

   // offer one request transaction after a random gap and hold it until accepted
   task automatic send_req(input op_type op, input logic [15:0] tid = 0,
                           input logic [31:0] dur = 0, input logic [31:0] delta = 0);
      int gap;
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {delta, dur, tid};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      predict_timer_op(op, tid, dur, delta);
   endtask

   // drop the request and hold off until every predicted response has arrived
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   // pick the id of a live timer, now and then a stray or zero id
   function automatic logic [15:0] pick_id();
      int live[$];
      int k;
      for (int i = 0; i < NSLOT; i++) if (tbl_valid[i]) live = {live, i};
      k = $urandom_range(0, 9);
      if (live.size() != 0 && k < 8) return tbl_id[live[$urandom_range(0, live.size() - 1)]];
      if (k == 8) return 16'd0;
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic test_basic_ops();
      logic [15:0] a;
      logic [15:0] b;
      send_req(OP_SET_TIMEOUT, 0, 32'd10);
      a = tbl_id[0];
      send_req(OP_SET_INTERVAL, 0, 32'd4);
      b = tbl_id[1];
      send_req(OP_QUERY, a);
      send_req(OP_PAUSE, b);
      send_req(OP_PAUSE, b);
      send_req(OP_QUERY, b);
      send_req(OP_TICK, 0, 0, 32'd3);
      send_req(OP_RESUME, b);
      send_req(OP_RESUME, b);
      send_req(OP_TICK, 0, 0, 32'd13);
      send_req(OP_QUERY, b);
      send_req(OP_CANCEL, b);
      send_req(OP_QUERY, b);
      send_req(OP_CANCEL_ALL);
   endtask

   task automatic test_special_cases();
      send_req(OP_SET_INTERVAL, 0, 32'd0);          // zero interval refused
      send_req(OP_SET_TIMEOUT, 0, 32'd0);           // zero delay fires on a zero tick
      send_req(OP_TICK, 0, 0, 32'd0);
      send_req(OP_CANCEL, 16'd0);                   // id zero
      send_req(OP_QUERY, 16'hFFFF);                 // unknown id
      send_req(OP_SET_INTERVAL, 0, 32'hFFFF_FFFF);
      send_req(OP_SET_TIMEOUT, 0, 32'hFFFF_FFFF);
      send_req(OP_SET_INTERVAL, 0, 32'd7);
      send_req(OP_TICK, 0, 0, 32'hFFFF_FFFF);       // overdue periodic fires once
      for (int i = 0; i < 14; i++) send_req(OP_SET_INTERVAL, 0, 32'd1);
      send_req(OP_SET_TIMEOUT, 0, 32'd5);           // table full
      send_req(OP_TICK, 0, 0, 32'd1);               // the interval-one slots fire
      send_req(OP_CANCEL_ALL);
   endtask

   // hold the receiver off while requests keep coming, then let the sender drain
   task automatic test_backpressure();
      wait_drained();
      hold_cycles = 400;
      for (int i = 0; i < 10; i++) send_req(OP_SET_INTERVAL, 0, 32'($urandom_range(1, 9)));
      send_req(OP_TICK, 0, 0, 32'd20);
      wait_drained();
      send_req(OP_CANCEL_ALL);
   endtask

   task automatic test_random(input int n);
      int k;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) begin gap_max = 0; stall_max = 0; end
         if (i == n / 2 + 30) begin gap_max = 13; stall_max = 13; end
         k = $urandom_range(0, 99);
         if (k < 35)
            send_req(k < 18 ? OP_SET_TIMEOUT : OP_SET_INTERVAL, 16'($urandom_range(0, 65535)),
                     ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 40)));
         else if (k < 60)
            send_req(OP_TICK, 16'($urandom_range(0, 65535)), $urandom,
                     ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 30)));
         else if (k < 97)
            send_req(op_type'($urandom_range(OP_CANCEL, OP_QUERY)), pick_id(), $urandom,
                     $urandom);
         else
            send_req(OP_CANCEL_ALL, 16'($urandom_range(0, 65535)), $urandom, $urandom);
      end
   endtask

   // receiver: random stall per response, long hold when asked, compare on acceptance
   initial begin
      timer_rsp_type e;
      int          n;
      logic [55:0] d;
      forever begin
         n = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid || reset);
         d = rsp_tdata;
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response", 0, d);
         end else begin
            e = expected_rsp.pop_front();
            if (d[1:0] != e.status)     report_mismatch("status", e.status, d[1:0]);
            if (d[17:2] != e.result_id) report_mismatch("result_id", e.result_id, d[17:2]);
            if (d[18] != e.fired)       report_mismatch("fired", e.fired, d[18]);
            if (d[19] != e.exists)      report_mismatch("exists", e.exists, d[19]);
            if (d[20] != e.active)      report_mismatch("active", e.active, d[20]);
            if (d[52:21] != e.remaining) report_mismatch("remaining", e.remaining, d[52:21]);
            if (rsp_tlast != e.last)    report_mismatch("last", e.last, rsp_tlast);
         end
      end
   end

   // watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      clear_table();
      tbl_next_id = 16'd1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_special_cases();
      test_backpressure();
      test_random(130);
      wait_drained();
      repeat (600) @(posedge clock);
      if (expected_rsp.size() != 0) report_mismatch("responses missing", 0, expected_rsp.size());
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
